// ----- hdl/dmmp_pkg.sv -----
// ----------------------------------------------------------------------------
// dmmp_pkg
// Shared constants and types for the minimum mean path table.
// ----------------------------------------------------------------------------
package dmmp_pkg;

  localparam int MAX_NODES   = 64;
  localparam int NODE_BITS   = $clog2(MAX_NODES);
  localparam int CELL_BITS   = 2 * NODE_BITS;
  localparam int CELLS       = MAX_NODES * MAX_NODES;
  localparam int WEIGHT_BITS = 20;
  localparam int SUM_BITS    = 26;
  localparam int LEN_BITS    = 6;
  localparam int CFG_BITS    = 7;
  localparam int COST_W      = SUM_BITS + 1;
  localparam int BEST_W      = SUM_BITS + LEN_BITS;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR,
    S_INIT,
    S_REL,
    S_TAIL,
    S_UPD,
    S_QRD,
    S_QOUT,
    S_DONE
  } state_t;

  // control from the sequencer to the min accumulator
  typedef struct packed {
    logic clear;
    logic take;
  } acc_ctl_t;

endpackage

// ----- hdl/dmmp_ram.sv -----
// ----------------------------------------------------------------------------
// dmmp_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
module dmmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/dmmp_min_acc.sv -----
// ----------------------------------------------------------------------------
// dmmp_min_acc
// Running minimum of cost plus edge weight over the predecessors of a node.
// ----------------------------------------------------------------------------
module dmmp_min_acc (
  input  logic                              clk,
  input  dmmp_pkg::acc_ctl_t                ctl,
  input  logic [dmmp_pkg::WEIGHT_BITS-1:0]  weight,
  input  logic [dmmp_pkg::COST_W-1:0]       cost,
  output logic                              have,
  output logic [dmmp_pkg::SUM_BITS-1:0]     low
);
  import dmmp_pkg::*;

  logic                acc_have;
  logic [SUM_BITS-1:0] acc_low;
  logic                cur_ok;
  logic [SUM_BITS-1:0] cur_sum;

  // candidate from the current predecessor
  assign cur_ok  = ctl.take && (weight != '0) && cost[SUM_BITS];
  assign cur_sum = cost[SUM_BITS-1:0] + SUM_BITS'(weight);

  // merge candidate with the held minimum
  always_comb begin
    have = acc_have;
    low  = acc_low;
    if (cur_ok && (!acc_have || cur_sum < acc_low)) begin
      have = 1'b1;
      low  = cur_sum;
    end
  end

  // hold the minimum, drop it between nodes
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_have <= 1'b0;
      acc_low  <= '0;
    end else begin
      acc_have <= have;
      acc_low  <= low;
    end
  end

endmodule

// ----- hdl/dag_min_mean_path_table.sv -----
// ----------------------------------------------------------------------------
// dag_min_mean_path_table
// Edge table, layered relaxation per source and a best-ratio table per pair.
// ----------------------------------------------------------------------------
//  channel   direction  signals
//  request   in         in_valid/in_ready: command, src_node, dst_node,
//                       edge_weight
//  result    out        out_valid/out_ready: reachable, path_sum, path_edges
//  config    in         node_count_we, node_count (no wait)
//
//  Clear writes one edge entry per cycle. After a change the first query on more
//  than one node rebuilds the tables, reading edges through the single edge RAM read port.
//  Reset runs a clearing pass over every edge RAM entry, in_ready low.
//  A finished result waits in the output register; the next request is taken.
// ----------------------------------------------------------------------------
module dag_min_mean_path_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        command,
  input  logic [dmmp_pkg::NODE_BITS-1:0]    src_node,
  input  logic [dmmp_pkg::NODE_BITS-1:0]    dst_node,
  input  logic [dmmp_pkg::WEIGHT_BITS-1:0]  edge_weight,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              reachable,
  output logic [dmmp_pkg::SUM_BITS-1:0]     path_sum,
  output logic [dmmp_pkg::LEN_BITS-1:0]     path_edges,
  input  logic                              node_count_we,
  input  logic [dmmp_pkg::CFG_BITS-1:0]     node_count
);
  import dmmp_pkg::*;

  state_t state, state_next;

  // registers
  logic [NODE_BITS-1:0]   n_m1;
  logic                   stale;
  logic                   pend;
  logic [CELL_BITS-1:0]   clr_cnt;
  logic [1:0]             cmd_r;
  logic [NODE_BITS-1:0]   a_r, b_r;
  logic [WEIGHT_BITS-1:0] w_r;
  logic [NODE_BITS-1:0]   s, v, u;
  logic [LEN_BITS-1:0]    len;
  logic                   fin_have;
  logic [SUM_BITS-1:0]    fin_low;
  logic                   res_reach;
  logic [SUM_BITS-1:0]    res_sum;
  logic [LEN_BITS-1:0]    res_edges;

  // memory ports
  logic                   e_we;
  logic [CELL_BITS-1:0]   e_waddr, e_raddr;
  logic [WEIGHT_BITS-1:0] e_wdata, e_rdata;
  logic                   c_we;
  logic [NODE_BITS:0]     c_waddr, c_raddr;
  logic [COST_W-1:0]      c_wdata, c_rdata;
  logic                   b_we;
  logic [CELL_BITS-1:0]   b_waddr, b_raddr;
  logic [BEST_W-1:0]      b_wdata, b_rdata;

  acc_ctl_t               acc_ctl;
  logic                   acc_have;
  logic [SUM_BITS-1:0]    acc_low;

  logic                   add_ok, pair_ok, better;
  logic [SUM_BITS-1:0]    bs;
  logic [LEN_BITS-1:0]    bl;
  logic [SUM_BITS+LEN_BITS-1:0] prod_new, prod_old;

  dmmp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(CELLS)) u_edge (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  dmmp_ram #(.WIDTH(COST_W), .DEPTH(2 * MAX_NODES)) u_cost (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  dmmp_ram #(.WIDTH(BEST_W), .DEPTH(CELLS)) u_best (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  dmmp_min_acc u_acc (
    .clk(clk), .ctl(acc_ctl), .weight(e_rdata), .cost(c_rdata),
    .have(acc_have), .low(acc_low)
  );

  // request checks and ratio compare
  assign add_ok  = (src_node <= n_m1) && (dst_node <= n_m1) && (src_node != dst_node)
                   && (edge_weight != '0);
  assign pair_ok = (a_r <= n_m1) && (b_r <= n_m1) && (a_r != b_r);
  assign bs       = b_rdata[BEST_W-1:LEN_BITS];
  assign bl       = b_rdata[LEN_BITS-1:0];
  assign prod_new = fin_low * bl;
  assign prod_old = bs * len;
  assign better   = fin_have && (v != s) && ((bl == '0) || (prod_new < prod_old));

  assign in_ready   = (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory control
  always_comb begin
    state_next  = state;
    e_we        = 1'b0;
    e_waddr     = {a_r, b_r};
    e_wdata     = w_r;
    e_raddr     = {a_r, b_r};
    c_we        = 1'b0;
    c_waddr     = {1'b0, u};
    c_wdata     = {(u == s), {SUM_BITS{1'b0}}};
    c_raddr     = {~len[0], u};
    b_we        = 1'b0;
    b_waddr     = {s, v};
    b_wdata     = {fin_low, len};
    b_raddr     = {a_r, b_r};
    acc_ctl.clear = 1'b1;
    acc_ctl.take  = 1'b0;
    case (state)
      S_CLR: begin
        e_we    = 1'b1;
        e_waddr = clr_cnt;
        e_wdata = '0;
        if (clr_cnt == '1) begin
          state_next = pend ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (command)
            CMD_CLEAR: state_next = S_CLR;
            CMD_ADD:   state_next = add_ok ? S_ADD_RD : S_DONE;
            CMD_QUERY: state_next = (stale && n_m1 != '0) ? S_INIT : S_QRD;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_ADD_RD: state_next = S_ADD_WR;
      S_ADD_WR: begin
        e_we       = (e_rdata == '0) || (w_r < e_rdata);
        state_next = S_DONE;
      end
      S_INIT: begin
        c_we = 1'b1;
        if (u == n_m1) begin
          state_next = S_REL;
        end
      end
      S_REL: begin
        // first read is still in flight: drop the held minimum instead
        e_raddr       = {u, v};
        acc_ctl.clear = (u == '0);
        acc_ctl.take  = (u != '0);
        if (u == n_m1) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        acc_ctl.take = 1'b1;
        c_we    = 1'b1;
        c_waddr = {len[0], v};
        c_wdata = {acc_have, acc_have ? acc_low : {SUM_BITS{1'b0}}};
        b_raddr = {s, v};
        state_next = S_UPD;
      end
      S_UPD: begin
        if (len == LEN_BITS'(1)) begin
          b_we    = 1'b1;
          b_wdata = (fin_have && v != s) ? {fin_low, len} : '0;
        end else begin
          b_we    = better;
        end
        if (v != n_m1) begin
          state_next = S_REL;
        end else if (len != LEN_BITS'(n_m1)) begin
          state_next = S_REL;
        end else if (s != n_m1) begin
          state_next = S_INIT;
        end else begin
          state_next = S_QRD;
        end
      end
      S_QRD:  state_next = S_QOUT;
      S_QOUT: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      n_m1      <= NODE_BITS'(MAX_NODES - 1);
      stale     <= 1'b1;
      pend      <= 1'b0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      s         <= '0;
      v         <= '0;
      u         <= '0;
      len       <= '0;
    end else begin
      if (node_count_we) begin
        if (node_count == '0) begin
          n_m1 <= '0;
        end else if (node_count > CFG_BITS'(MAX_NODES)) begin
          n_m1 <= NODE_BITS'(MAX_NODES - 1);
        end else begin
          n_m1 <= NODE_BITS'(node_count - CFG_BITS'(1));
        end
      end
      // mark the table stale on any change, current after a rebuild or a single-node query
      if (node_count_we || (state == S_IDLE && in_valid &&
          (command == CMD_CLEAR || (command == CMD_ADD && add_ok)))) begin
        stale <= 1'b1;
      end else if ((state == S_IDLE && in_valid && command == CMD_QUERY && n_m1 == '0) ||
                   (state == S_UPD && v == n_m1 && len == LEN_BITS'(n_m1) &&
                    s == n_m1)) begin
        stale <= 1'b0;
      end
      // load a finished result, drop an accepted one
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + CELL_BITS'(1);
        end
        S_IDLE: begin
          if (in_valid) begin
            pend      <= 1'b1;
            clr_cnt   <= '0;
            s         <= '0;
            u         <= '0;
            res_reach <= 1'b0;
            res_sum   <= '0;
            res_edges <= '0;
          end
        end
        S_INIT: begin
          if (u == n_m1) begin
            u   <= '0;
            v   <= '0;
            len <= LEN_BITS'(1);
          end else begin
            u <= u + NODE_BITS'(1);
          end
        end
        S_REL: begin
          u <= (u == n_m1) ? '0 : u + NODE_BITS'(1);
        end
        S_TAIL: begin
          fin_have <= acc_have;
          fin_low  <= acc_low;
        end
        S_UPD: begin
          if (v != n_m1) begin
            v <= v + NODE_BITS'(1);
          end else begin
            v <= '0;
            if (len != LEN_BITS'(n_m1)) begin
              len <= len + LEN_BITS'(1);
            end else if (s != n_m1) begin
              s <= s + NODE_BITS'(1);
              u <= '0;
            end
          end
        end
        S_QOUT: begin
          if (pair_ok && b_rdata[LEN_BITS-1:0] != '0) begin
            res_reach <= 1'b1;
            res_sum   <= b_rdata[BEST_W-1:LEN_BITS];
            res_edges <= b_rdata[LEN_BITS-1:0];
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            pend      <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_r <= command;
      a_r   <= src_node;
      b_r   <= dst_node;
      w_r   <= edge_weight;
    end
    if (state == S_DONE && (!out_valid || out_ready)) begin
      reachable  <= res_reach && (cmd_r == CMD_QUERY);
      path_sum   <= res_sum;
      path_edges <= res_edges;
    end
  end

endmodule
